FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Clocked on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/lbbt_pkg.sv
// Shared constants, codes and types for the label bounding box table.
// No dependencies; every module of the block imports it.
package lbbt_pkg;

    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int COORD_BITS = 15;

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam int PIX_W   = 15;
    localparam int LABEL_W = 16;
    localparam int OUT_W   = 16;
    localparam int CFG_W   = 7;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic CFG_GRID_SAMPLES = 1'b0;
    localparam logic CFG_GRID_LINES   = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord min_s;
        t_coord max_s;
        t_coord min_l;
        t_coord max_l;
    } t_bnd;

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic rd_en;
        logic upd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_read;
    } t_stat;

endpackage

FILE: rtl/core/lbbt_ctrl.sv
// Sequencer for the label bounding box table: clearing pass, item steps and
// output valid. Depends on lbbt_pkg.
module lbbt_ctrl import lbbt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_UPD   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_UPD;
            end
            ST_UPD: begin
                // hold while a read result has nowhere to go
                if (!(i_stat.is_read && r_out_valid && i_out_stall)) begin
                    o_cmd.upd      = 1'b1;
                    o_cmd.load_out = i_stat.is_read;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/lbbt_dpath.sv
// Datapath of the label bounding box table: label check, used-bit and bounds
// memories, box update and result register. Depends on lbbt_pkg.
module lbbt_dpath import lbbt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_stat                     o_stat,
    input  logic [CFG_W-1:0]          i_grid_samples,
    input  logic [CFG_W-1:0]          i_grid_lines,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [PIX_W-1:0]          i_pixel_sample,
    input  logic [PIX_W-1:0]          i_pixel_line,
    input  logic signed [LABEL_W-1:0] i_label_col,
    input  logic signed [LABEL_W-1:0] i_label_row,
    output logic                      o_entry_found,
    output logic signed [OUT_W-1:0]   o_sample_offset,
    output logic signed [OUT_W-1:0]   o_line_offset,
    output logic [OUT_W-1:0]          o_sample_extent,
    output logic [OUT_W-1:0]          o_line_extent
);

    logic               r_used_mem [CELLS];
    t_bnd               r_bnd_mem  [CELLS];
    logic [IDX_W-1:0]   r_clr_addr;

    logic [FUNC_W-1:0]  r_func;
    t_coord             r_s;
    t_coord             r_l;
    logic               r_ok;
    logic [IDX_W-1:0]   r_idx;
    logic               r_rd_used;
    t_bnd               r_rd_bnd;

    logic [LABEL_W-1:0] col_u;
    logic [LABEL_W-1:0] row_u;
    logic               col_ok;
    logic               row_ok;
    logic [31:0]        idx_full;
    t_bnd               n_bnd;
    logic               we_acc;
    logic               we_clr;
    logic [COORD_BITS:0] ext_s;
    logic [COORD_BITS:0] ext_l;

    // label check and table index
    assign col_u  = i_label_col;
    assign row_u  = i_label_row;
    assign col_ok = !col_u[LABEL_W-1] && (col_u != '0)
                    && (col_u <= LABEL_W'(i_grid_samples))
                    && (col_u <= LABEL_W'(GRID_COLS));
    assign row_ok = !row_u[LABEL_W-1] && (row_u != '0)
                    && (row_u <= LABEL_W'(i_grid_lines))
                    && (row_u <= LABEL_W'(GRID_ROWS));
    assign idx_full = 32'(col_u - 16'd1) * 32'(GRID_ROWS) + 32'(row_u - 16'd1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= i_func;
            r_s    <= i_pixel_sample[COORD_BITS-1:0];
            r_l    <= i_pixel_line[COORD_BITS-1:0];
            r_ok   <= col_ok && row_ok;
            r_idx  <= idx_full[IDX_W-1:0];
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == IDX_W'(CELLS - 1));
    assign o_stat.is_read    = (r_func == FUNC_READ);

    // box update: first pixel loads all four bounds
    always_comb begin
        if (!r_rd_used) begin
            n_bnd = '{min_s: r_s, max_s: r_s, min_l: r_l, max_l: r_l};
        end else begin
            n_bnd       = r_rd_bnd;
            if (r_s < r_rd_bnd.min_s) n_bnd.min_s = r_s;
            if (r_s > r_rd_bnd.max_s) n_bnd.max_s = r_s;
            if (r_l < r_rd_bnd.min_l) n_bnd.min_l = r_l;
            if (r_l > r_rd_bnd.max_l) n_bnd.max_l = r_l;
        end
    end

    assign we_acc = i_cmd.upd && r_ok && (r_func == FUNC_ACCUM);
    assign we_clr = i_cmd.upd && r_ok && (r_func == FUNC_CLEAR);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_used_mem[r_clr_addr] <= 1'b0;
        end else if (we_acc) begin
            r_used_mem[r_idx] <= 1'b1;
        end else if (we_clr) begin
            r_used_mem[r_idx] <= 1'b0;
        end
        if (we_acc) begin
            r_bnd_mem[r_idx] <= n_bnd;
        end
        if (i_cmd.rd_en) begin
            r_rd_used <= r_used_mem[r_idx];
            r_rd_bnd  <= r_bnd_mem[r_idx];
        end
    end

    // result register
    assign ext_s = {1'b0, r_rd_bnd.max_s} - {1'b0, r_rd_bnd.min_s} + 1'b1;
    assign ext_l = {1'b0, r_rd_bnd.max_l} - {1'b0, r_rd_bnd.min_l} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_ok && r_rd_used) begin
                o_entry_found   <= 1'b1;
                o_sample_offset <= OUT_W'(r_rd_bnd.min_s);
                o_line_offset   <= OUT_W'(r_rd_bnd.min_l);
                o_sample_extent <= OUT_W'(ext_s);
                o_line_extent   <= OUT_W'(ext_l);
            end else begin
                o_entry_found   <= 1'b0;
                o_sample_offset <= '1;
                o_line_offset   <= '1;
                o_sample_extent <= '0;
                o_line_extent   <= '0;
            end
        end
    end

endmodule

FILE: rtl/core/label_bounding_box_table_core.sv
// Top level of the label bounding box table: configuration registers and the
// sequencer and datapath. Depends on lbbt_pkg, lbbt_ctrl, lbbt_dpath, assert_macros.svh.
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_stall    i_func, i_pixel_*, i_label_*
//   output    o_out_valid / i_out_stall  o_entry_found, o_*_offset, o_*_extent
//   config    i_cfg_we                   i_cfg_index, i_cfg_data
//
// Each item steps through capture and label check, memory read, then update or
// result load before the next item is accepted.
// After reset a clearing pass over all CELLS (4096) entries empties the used bits;
// no item is taken until it ends, configuration writes are.
// A read item waits in its last step while the output register is full and
// stalled; accumulate and clear items are never held by the output side.
module label_bounding_box_table_core import lbbt_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic [PIX_W-1:0]          i_pixel_sample,
    input  logic [PIX_W-1:0]          i_pixel_line,
    input  logic signed [LABEL_W-1:0] i_label_col,
    input  logic signed [LABEL_W-1:0] i_label_row,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_entry_found,
    output logic signed [OUT_W-1:0]   o_sample_offset,
    output logic signed [OUT_W-1:0]   o_line_offset,
    output logic [OUT_W-1:0]          o_sample_extent,
    output logic [OUT_W-1:0]          o_line_extent,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    logic [CFG_W-1:0] r_grid_samples;
    logic [CFG_W-1:0] r_grid_lines;
    t_cmd             cmd;
    t_stat            stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_samples <= CFG_RESET;
            r_grid_lines   <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_SAMPLES: r_grid_samples <= i_cfg_data;
                CFG_GRID_LINES:   r_grid_lines   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lbbt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lbbt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_grid_samples  (r_grid_samples),
        .i_grid_lines    (r_grid_lines),
        .i_func          (i_func),
        .i_pixel_sample  (i_pixel_sample),
        .i_pixel_line    (i_pixel_line),
        .i_label_col     (i_label_col),
        .i_label_row     (i_label_row),
        .o_entry_found   (o_entry_found),
        .o_sample_offset (o_sample_offset),
        .o_line_offset   (o_line_offset),
        .o_sample_extent (o_sample_extent),
        .o_line_extent   (o_line_extent)
    );

`include "assert_macros.svh"

    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_IMPLY(a_load_into_free_slot, cmd.load_out, !(o_out_valid && i_out_stall))
    `ASSERT_IMPLY(a_upd_after_read, cmd.upd, $past(cmd.rd_en) || $past(o_in_stall && !cmd.upd))
    `ASSERT_ALWAYS(a_clear_excludes_item, !(cmd.clear_step && (cmd.load_item || cmd.upd)))

endmodule
